/* rtl/core/ipv4rx_pkg.sv */
package ipv4rx_pkg;

   // Verdict codes
   typedef logic [2:0] verdict_type;
   localparam verdict_type VERDICT_OK          = 3'd0;
   localparam verdict_type VERDICT_CHECKSUM    = 3'd1;
   localparam verdict_type VERDICT_VERSION     = 3'd2;
   localparam verdict_type VERDICT_TOO_LONG    = 3'd3;
   localparam verdict_type VERDICT_FRAGMENT    = 3'd4;
   localparam verdict_type VERDICT_NOT_OURS    = 3'd5;
   localparam verdict_type VERDICT_UNSUPPORTED = 3'd6;
   localparam verdict_type VERDICT_BAD_IHL     = 3'd7;

   // Transport dispatch codes
   typedef logic [1:0] dispatch_type;
   localparam dispatch_type DISPATCH_NONE = 2'd0;
   localparam dispatch_type DISPATCH_ICMP = 2'd1;
   localparam dispatch_type DISPATCH_UDP  = 2'd2;

   // Protocol numbers and header constants
   localparam logic [7:0]  PROTO_ICMP    = 8'd1;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [15:0] MF_BIT        = 16'h2000;
   localparam logic [15:0] OFFSET_MASK   = 16'h1FFF;
   localparam logic [3:0]  MIN_IHL       = 4'd5;
   localparam logic [3:0]  IP_VERSION    = 4'd4;
   localparam logic [15:0] MTU_RESET     = 16'd1500;
   localparam logic [31:0] HOST_RESET    = 32'd0;

   // Word positions within the header
   typedef logic [4:0] word_idx_type;
   localparam word_idx_type IDX_LENGTH    = 5'd1;
   localparam word_idx_type IDX_FRAGMENT  = 5'd3;
   localparam word_idx_type IDX_PROTOCOL  = 5'd4;
   localparam word_idx_type IDX_CHECKSUM  = 5'd5;
   localparam word_idx_type IDX_SOURCE_HI = 5'd6;
   localparam word_idx_type IDX_SOURCE_LO = 5'd7;
   localparam word_idx_type IDX_DEST_HI   = 5'd8;
   localparam word_idx_type IDX_DEST_LO   = 5'd9;

   // Register indexes of the configuration port
   typedef logic [3:0] csr_index_type;
   localparam csr_index_type CSR_HOST_ADDRESS = 4'd0;
   localparam csr_index_type CSR_MTU_LIMIT    = 4'd1;

   // Configuration in force
   typedef struct packed {
      logic [31:0] host_address;
      logic [15:0] mtu_limit;
   } cfg_type;

   // Finished header handed from the parser to the checker
   typedef struct packed {
      logic        bad_ihl;
      logic [5:0]  header_bytes;
      logic [15:0] sum;
      logic [15:0] checksum;
      logic [3:0]  version;
      logic [15:0] length;
      logic [15:0] fragment;
      logic [7:0]  protocol;
      logic [31:0] source;
      logic [31:0] destination;
   } fin_type;

endpackage

/* rtl/core/ipv4_receive_header_check.sv */
// IPv4 receive header check.
// Request channel: one 16-bit header word per transfer, in wire order, with
// req_first_word marking the first word of each header. A transfer happens
// at a clock edge with req_valid high and req_stall low.
// Response channel: one verdict per header after its last word (or at once
// for a header whose IHL is below 5), with dispatch, protocol, payload
// length, header length and both addresses. Words outside a header and
// headers cut short by a new first word give no response.
// Configuration channel: csr_index selects host address (0) or MTU limit
// (1); csr_ready is always high. Write only while the block is idle.
// The response passes the input, hand-over and result registers after the
// transfer of the last header word. Throughput: one word per cycle while
// req_stall is low; the header state takes one add per word.
// Reset clears all control state and sets the host address to 0 and the
// MTU limit to 1500; no response is pending after reset.
// When the receiver stalls a pending response, the whole pipeline holds
// and req_stall rises in the same cycle; nothing is lost or repeated.
module ipv4_receive_header_check
   import ipv4rx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_header_word,
   input  logic        req_first_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_verdict,
   output logic [1:0]  rsp_dispatch,
   output logic [7:0]  rsp_protocol_number,
   output logic [15:0] rsp_payload_length,
   output logic [5:0]  rsp_header_bytes,
   output logic [31:0] rsp_source_address,
   output logic [31:0] rsp_destination_address,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type cfg_ff;
   logic    advance;
   logic    fin_valid;
   fin_type fin;

   // Advance unless a response waits on a stalled receiver
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.host_address <= HOST_RESET;
         cfg_ff.mtu_limit    <= MTU_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HOST_ADDRESS: cfg_ff.host_address <= csr_data;
            CSR_MTU_LIMIT:    cfg_ff.mtu_limit    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   ipv4rx_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .req_valid       (req_valid),
      .req_header_word (req_header_word),
      .req_first_word  (req_first_word),
      .fin_valid       (fin_valid),
      .fin             (fin)
   );

   ipv4rx_check u_check (
      .clock                   (clock),
      .reset                   (reset),
      .advance                 (advance),
      .cfg                     (cfg_ff),
      .fin_valid               (fin_valid),
      .fin                     (fin),
      .rsp_valid               (rsp_valid),
      .rsp_verdict             (rsp_verdict),
      .rsp_dispatch            (rsp_dispatch),
      .rsp_protocol_number     (rsp_protocol_number),
      .rsp_payload_length      (rsp_payload_length),
      .rsp_header_bytes        (rsp_header_bytes),
      .rsp_source_address      (rsp_source_address),
      .rsp_destination_address (rsp_destination_address)
   );

endmodule

/* rtl/core/ipv4rx_parse.sv */
module ipv4rx_parse
   import ipv4rx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        req_valid,
   input  logic [15:0] req_header_word,
   input  logic        req_first_word,
   output logic        fin_valid,
   output fin_type     fin
);

   // Ones' complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      logic [16:0] t;
      s = {1'b0, a} + {1'b0, b};
      t = {1'b0, s[15:0]} + {16'd0, s[16]};
      return t[15:0];
   endfunction

   logic         in_valid_ff;
   logic [15:0]  in_word_ff;
   logic         in_first_ff;

   logic         active_ff, active_in;
   word_idx_type count_ff, count_in;
   logic [4:0]   expected_ff, expected_in;
   logic [15:0]  sum_ff, sum_in;
   logic [15:0]  checksum_ff, checksum_in;
   logic [3:0]   version_ff, version_in;
   logic [15:0]  length_ff, length_in;
   logic [15:0]  fragment_ff, fragment_in;
   logic [7:0]   protocol_ff, protocol_in;
   logic [31:0]  source_ff, source_in;
   logic [31:0]  dest_ff, dest_in;

   logic         fin_valid_ff, fin_valid_in;
   fin_type      fin_ff, fin_in;

   logic [3:0]   ihl;
   word_idx_type idx;
   logic [5:0]   idx_next;

   // Hold the accepted word in the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
      if (advance) begin
         in_word_ff  <= req_header_word;
         in_first_ff <= req_first_word;
      end
   end

   // Apply one word to the header state
   always_comb begin
      ihl          = in_word_ff[11:8];
      idx          = in_first_ff ? '0 : count_ff;
      idx_next     = {1'b0, idx} + 6'd1;

      active_in    = active_ff;
      count_in     = count_ff;
      expected_in  = expected_ff;
      sum_in       = in_first_ff ? '0 : sum_ff;
      checksum_in  = in_first_ff ? '0 : checksum_ff;
      version_in   = in_first_ff ? in_word_ff[15:12] : version_ff;
      length_in    = in_first_ff ? '0 : length_ff;
      fragment_in  = in_first_ff ? '0 : fragment_ff;
      protocol_in  = in_first_ff ? '0 : protocol_ff;
      source_in    = in_first_ff ? '0 : source_ff;
      dest_in      = in_first_ff ? '0 : dest_ff;
      fin_valid_in = 1'b0;
      fin_in       = '0;

      if (in_valid_ff) begin
         if (in_first_ff && ihl < MIN_IHL) begin
            // Reject a short header at once
            active_in           = 1'b0;
            count_in            = '0;
            fin_valid_in        = 1'b1;
            fin_in.bad_ihl      = 1'b1;
            fin_in.header_bytes = {ihl, 2'b00};
         end else if (in_first_ff || active_ff) begin
            if (in_first_ff) begin
               active_in   = 1'b1;
               expected_in = {ihl, 1'b0};
            end

            // Sum every word but the checksum, which is held aside
            if (idx == IDX_CHECKSUM) begin
               checksum_in = in_word_ff;
            end else begin
               sum_in = oc_add(sum_in, in_word_ff);
            end

            // Capture the fields as they pass
            case (idx)
               IDX_LENGTH:    length_in          = in_word_ff;
               IDX_FRAGMENT:  fragment_in        = in_word_ff;
               IDX_PROTOCOL:  protocol_in        = in_word_ff[7:0];
               IDX_SOURCE_HI: source_in[31:16]   = in_word_ff;
               IDX_SOURCE_LO: source_in[15:0]    = in_word_ff;
               IDX_DEST_HI:   dest_in[31:16]     = in_word_ff;
               IDX_DEST_LO:   dest_in[15:0]      = in_word_ff;
               default: ;
            endcase

            if (idx_next < {1'b0, expected_in}) begin
               count_in = idx_next[4:0];
            end else begin
               // Last word: hand the header to the checker
               active_in           = 1'b0;
               count_in            = '0;
               fin_valid_in        = 1'b1;
               fin_in.bad_ihl      = 1'b0;
               fin_in.header_bytes = {expected_in, 1'b0};
               fin_in.sum          = sum_in;
               fin_in.checksum     = checksum_in;
               fin_in.version      = version_in;
               fin_in.length       = length_in;
               fin_in.fragment     = fragment_in;
               fin_in.protocol     = protocol_in;
               fin_in.source       = source_in;
               fin_in.destination  = dest_in;
            end
         end
      end
   end

   // Advance the header state and the hand-over register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         count_ff     <= '0;
         expected_ff  <= '0;
         fin_valid_ff <= 1'b0;
      end else if (advance) begin
         fin_valid_ff <= fin_valid_in;
         if (in_valid_ff) begin
            active_ff   <= active_in;
            count_ff    <= count_in;
            expected_ff <= expected_in;
         end
      end
      if (advance) begin
         fin_ff <= fin_in;
         if (in_valid_ff) begin
            sum_ff      <= sum_in;
            checksum_ff <= checksum_in;
            version_ff  <= version_in;
            length_ff   <= length_in;
            fragment_ff <= fragment_in;
            protocol_ff <= protocol_in;
            source_ff   <= source_in;
            dest_ff     <= dest_in;
         end
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

endmodule

/* rtl/core/ipv4rx_check.sv */
module ipv4rx_check
   import ipv4rx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  cfg_type      cfg,
   input  logic         fin_valid,
   input  fin_type      fin,
   output logic         rsp_valid,
   output logic [2:0]   rsp_verdict,
   output logic [1:0]   rsp_dispatch,
   output logic [7:0]   rsp_protocol_number,
   output logic [15:0]  rsp_payload_length,
   output logic [5:0]   rsp_header_bytes,
   output logic [31:0]  rsp_source_address,
   output logic [31:0]  rsp_destination_address
);

   logic         valid_ff;
   verdict_type  verdict_ff, verdict_in;
   dispatch_type dispatch_ff, dispatch_in;
   logic [7:0]   protocol_ff, protocol_in;
   logic [15:0]  payload_ff, payload_in;
   logic [5:0]   hbytes_ff;
   logic [31:0]  source_ff, source_in;
   logic [31:0]  dest_ff, dest_in;

   logic [15:0]  hbytes_wide;

   // Run the checks in priority order
   always_comb begin
      hbytes_wide = {10'd0, fin.header_bytes};
      payload_in  = (fin.length >= hbytes_wide) ? fin.length - hbytes_wide : '0;
      protocol_in = fin.protocol;
      source_in   = fin.source;
      dest_in     = fin.destination;
      dispatch_in = DISPATCH_NONE;

      if (fin.bad_ihl) begin
         verdict_in  = VERDICT_BAD_IHL;
         payload_in  = '0;
         protocol_in = '0;
         source_in   = '0;
         dest_in     = '0;
      end else if (~fin.sum != fin.checksum) begin
         verdict_in = VERDICT_CHECKSUM;
      end else if (fin.version != IP_VERSION) begin
         verdict_in = VERDICT_VERSION;
      end else if (fin.length > cfg.mtu_limit) begin
         verdict_in = VERDICT_TOO_LONG;
      end else if ((fin.fragment & (MF_BIT | OFFSET_MASK)) != '0) begin
         verdict_in = VERDICT_FRAGMENT;
      end else if (cfg.host_address != '0 && fin.destination != cfg.host_address) begin
         verdict_in = VERDICT_NOT_OURS;
      end else if (fin.protocol == PROTO_ICMP) begin
         verdict_in  = VERDICT_OK;
         dispatch_in = DISPATCH_ICMP;
      end else if (fin.protocol == PROTO_UDP) begin
         verdict_in  = VERDICT_OK;
         dispatch_in = DISPATCH_UDP;
      end else begin
         verdict_in = VERDICT_UNSUPPORTED;
      end
   end

   // Load the result register; hold it while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= fin_valid;
      end
      if (advance) begin
         verdict_ff  <= verdict_in;
         dispatch_ff <= dispatch_in;
         protocol_ff <= protocol_in;
         payload_ff  <= payload_in;
         hbytes_ff   <= fin.header_bytes;
         source_ff   <= source_in;
         dest_ff     <= dest_in;
      end
   end

   assign rsp_valid               = valid_ff;
   assign rsp_verdict             = verdict_ff;
   assign rsp_dispatch            = dispatch_ff;
   assign rsp_protocol_number     = protocol_ff;
   assign rsp_payload_length      = payload_ff;
   assign rsp_header_bytes        = hbytes_ff;
   assign rsp_source_address      = source_ff;
   assign rsp_destination_address = dest_ff;

endmodule

/* rtl/core/ipv4rx_checker.sv */
module ipv4rx_checker
   import ipv4rx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_verdict,
   input logic [1:0]  rsp_dispatch,
   input logic [5:0]  rsp_header_bytes
);

   // A stalled response stays offered with the same verdict
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict))
      else $error("stalled response dropped or changed");

   // A pending stalled response holds back the request side
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request accepted while response stalled");

   // A passed header always names its transport
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_OK |->
         rsp_dispatch == DISPATCH_ICMP || rsp_dispatch == DISPATCH_UDP)
      else $error("passed header without dispatch");

   // A rejected header is never dispatched
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != VERDICT_OK |-> rsp_dispatch == DISPATCH_NONE)
      else $error("rejected header dispatched");

   // Header length below 20 bytes exactly when the IHL is rejected
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == VERDICT_BAD_IHL) == (rsp_header_bytes < 6'd20))
      else $error("header length and IHL verdict disagree");

endmodule

bind ipv4_receive_header_check ipv4rx_checker u_ipv4rx_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench
   import ipv4rx_pkg::*;
();

   localparam int CLOCK_HIGH = 6;
   localparam int CLOCK_LOW = 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_OFF_CYCLES = 240;
   localparam int PHASE_WORDS = 160;
   localparam int MAX_REPORTS = 10;
   localparam csr_index_type CSR_UNMAPPED = 4'd15;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [15:0] DONT_FRAGMENT = 16'h4000;

   typedef struct packed {
      verdict_type  verdict;
      dispatch_type dispatch;
      logic [7:0]   protocol;
      logic [15:0]  payload;
      logic [5:0]   header_bytes;
      logic [31:0]  source;
      logic [31:0]  destination;
   } header_result_type;

   typedef struct packed {
      logic [15:0] word;
      logic        first;
   } wire_word_type;

   typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_header_word;
   logic        req_first_word;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_verdict;
   logic [1:0]  rsp_dispatch;
   logic [7:0]  rsp_protocol_number;
   logic [15:0] rsp_payload_length;
   logic [5:0]  rsp_header_bytes;
   logic [31:0] rsp_source_address;
   logic [31:0] rsp_destination_address;
   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_index;
   logic [31:0] csr_data;

   // Configuration as the block should currently hold it
   logic [31:0] cfg_host;
   logic [15:0] cfg_mtu;

   // Header tracking state mirrored from the block
   logic        hdr_active;
   logic [4:0]  hdr_count;
   logic [4:0]  hdr_expected;
   logic [15:0] hdr_sum;
   logic [15:0] hdr_checksum;
   logic [3:0]  hdr_version;
   logic [15:0] hdr_length;
   logic [15:0] hdr_fragment;
   logic [7:0]  hdr_protocol;
   logic [31:0] hdr_source;
   logic [31:0] hdr_destination;

   wire_word_type     wire_words[$];
   header_result_type expected_verdicts[$];

   logic        req_taken;
   int          burst_left;
   int          gap_left;
   int          hold_off_left;
   int          hold_offs_asked;
   int          hold_offs_served;
   int          mode_left;
   rx_mode_type rx_mode;

   int words_queued;
   int words_taken;
   int headers_checked;
   int error_count;
   int config_phases;
   int cycle_count;
   int verdict_seen[8];

   ipv4_receive_header_check uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_header_word        (req_header_word),
      .req_first_word         (req_first_word),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_verdict            (rsp_verdict),
      .rsp_dispatch           (rsp_dispatch),
      .rsp_protocol_number    (rsp_protocol_number),
      .rsp_payload_length     (rsp_payload_length),
      .rsp_header_bytes       (rsp_header_bytes),
      .rsp_source_address     (rsp_source_address),
      .rsp_destination_address(rsp_destination_address),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   always begin
      #CLOCK_LOW clock = 1'b1;
      #CLOCK_HIGH clock = 1'b0;
   end

   // Ones' complement add with end-around carry
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   function automatic string describe(input header_result_type r);
      return $sformatf("verdict %0d dispatch %0d proto %0d payload %0d hbytes %0d src %h dst %h",
                       r.verdict, r.dispatch, r.protocol, r.payload, r.header_bytes,
                       r.source, r.destination);
   endfunction

   // Advance the header tracker by one transferred word; queue a verdict when one is due
   function automatic void track_header_word(input logic [15:0] w, input logic first);
      header_result_type r;
      logic [3:0]        ihl;
      logic [4:0]        idx;
      logic [5:0]        hbytes;
      r = '0;
      if (first) begin
         ihl = w[11:8];
         if (ihl < MIN_IHL) begin
            hdr_active = 1'b0;
            hdr_count = '0;
            r.verdict = VERDICT_BAD_IHL;
            r.header_bytes = {ihl, 2'b00};
            expected_verdicts.push_back(r);
            return;
         end
         hdr_active = 1'b1;
         hdr_count = '0;
         hdr_expected = {ihl, 1'b0};
         hdr_sum = '0;
         hdr_checksum = '0;
         hdr_length = '0;
         hdr_fragment = '0;
         hdr_protocol = '0;
         hdr_source = '0;
         hdr_destination = '0;
         hdr_version = w[15:12];
      end else if (!hdr_active) begin
         return;
      end

      // The checksum word is held aside and counts as zero in the sum
      idx = hdr_count;
      if (idx == IDX_CHECKSUM) hdr_checksum = w;
      else hdr_sum = ones_add(hdr_sum, w);

      case (idx)
         IDX_LENGTH:    hdr_length = w;
         IDX_FRAGMENT:  hdr_fragment = w;
         IDX_PROTOCOL:  hdr_protocol = w[7:0];
         IDX_SOURCE_HI: hdr_source[31:16] = w;
         IDX_SOURCE_LO: hdr_source[15:0] = w;
         IDX_DEST_HI:   hdr_destination[31:16] = w;
         IDX_DEST_LO:   hdr_destination[15:0] = w;
         default: ;
      endcase

      if (int'(idx) + 1 < int'(hdr_expected)) begin
         hdr_count = idx + 5'd1;
         return;
      end

      hdr_active = 1'b0;
      hdr_count = '0;
      hbytes = {hdr_expected, 1'b0};
      r.header_bytes = hbytes;
      r.protocol = hdr_protocol;
      r.source = hdr_source;
      r.destination = hdr_destination;
      r.payload = (hdr_length >= {10'd0, hbytes}) ? hdr_length - {10'd0, hbytes} : 16'd0;
      r.dispatch = DISPATCH_NONE;

      // First failing check wins
      if (~hdr_sum != hdr_checksum) r.verdict = VERDICT_CHECKSUM;
      else if (hdr_version != IP_VERSION) r.verdict = VERDICT_VERSION;
      else if (hdr_length > cfg_mtu) r.verdict = VERDICT_TOO_LONG;
      else if ((hdr_fragment & (MF_BIT | OFFSET_MASK)) != '0) r.verdict = VERDICT_FRAGMENT;
      else if (cfg_host != '0 && hdr_destination != cfg_host) r.verdict = VERDICT_NOT_OURS;
      else if (hdr_protocol == PROTO_ICMP) begin
         r.verdict = VERDICT_OK;
         r.dispatch = DISPATCH_ICMP;
      end else if (hdr_protocol == PROTO_UDP) begin
         r.verdict = VERDICT_OK;
         r.dispatch = DISPATCH_UDP;
      end else r.verdict = VERDICT_UNSUPPORTED;
      expected_verdicts.push_back(r);
   endfunction

   // Build a header in wire order; keep_words from 1 to count - 1 cuts it short
   function automatic void queue_header(input logic [3:0] version, input logic [3:0] ihl,
                                        input logic [15:0] length, input logic [15:0] fragment,
                                        input logic [7:0] protocol, input logic [31:0] source,
                                        input logic [31:0] destination, input logic sum_ok,
                                        input int keep_words);
      logic [15:0] words[30];
      logic [15:0] sum;
      logic [15:0] flip;
      logic [7:0]  tos;
      logic [7:0]  ttl;
      int          count;
      int          i;
      tos = 8'($urandom);
      ttl = 8'($urandom);
      flip = 16'($urandom_range(1, 65535));
      count = (ihl < MIN_IHL) ? 1 : 2 * int'(ihl);
      for (i = 0; i < 30; i++) words[i] = 16'($urandom);
      words[0] = {version, ihl, tos};
      words[IDX_LENGTH] = length;
      words[IDX_FRAGMENT] = fragment;
      words[IDX_PROTOCOL] = {ttl, protocol};
      words[IDX_SOURCE_HI] = source[31:16];
      words[IDX_SOURCE_LO] = source[15:0];
      words[IDX_DEST_HI] = destination[31:16];
      words[IDX_DEST_LO] = destination[15:0];
      sum = '0;
      for (i = 0; i < count; i++) if (i != IDX_CHECKSUM) sum = ones_add(sum, words[i]);
      words[IDX_CHECKSUM] = sum_ok ? ~sum : ~sum ^ flip;
      if (keep_words > 0 && keep_words < count) count = keep_words;
      for (i = 0; i < count; i++) wire_words.push_back('{word: words[i], first: (i == 0)});
      words_queued += count;
   endfunction

   // Words outside any header
   function automatic void queue_stray_words(input int n);
      logic [15:0] w;
      for (int i = 0; i < n; i++) begin
         w = 16'($urandom);
         wire_words.push_back('{word: w, first: 1'b0});
      end
   endfunction

   // Mostly well-formed headers with random content, some broken or cut short
   function automatic void queue_random_header();
      logic [3:0]  version;
      logic [3:0]  ihl;
      logic [15:0] length;
      logic [15:0] fragment;
      logic [7:0]  protocol;
      logic [31:0] destination;
      int          hbytes;
      int          pick;
      int          keep;
      pick = $urandom_range(0, 99);
      if (pick < 70) ihl = MIN_IHL;
      else if (pick < 90) ihl = 4'($urandom_range(6, 15));
      else ihl = 4'($urandom_range(0, 4));
      hbytes = 4 * int'(ihl);
      if ($urandom_range(0, 6) == 0) version = 4'($urandom);
      else version = IP_VERSION;
      case ($urandom_range(0, 3))
         0: length = 16'($urandom_range(hbytes, int'(cfg_mtu)));
         1: length = 16'($urandom);
         2: length = 16'($urandom_range(0, hbytes));
         default: length = cfg_mtu + 16'($urandom_range(0, 1));
      endcase
      case ($urandom_range(0, 7))
         0: fragment = MF_BIT;
         1: fragment = 16'($urandom_range(1, 65535)) & OFFSET_MASK;
         2: fragment = 16'($urandom);
         3: fragment = DONT_FRAGMENT;
         default: fragment = '0;
      endcase
      case ($urandom_range(0, 4))
         0, 1: protocol = PROTO_ICMP;
         2, 3: protocol = PROTO_UDP;
         default: protocol = 8'($urandom);
      endcase
      if ($urandom_range(0, 1) == 0) destination = cfg_host;
      else destination = $urandom;
      keep = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 29) : 0;
      if ($urandom_range(0, 19) == 0) queue_stray_words($urandom_range(1, 3));
      queue_header(version, ihl, length, fragment, protocol, $urandom, destination,
                   $urandom_range(0, 7) != 0, keep);
   endfunction

   task automatic write_register(input csr_index_type index, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_HOST_ADDRESS: cfg_host = value;
         CSR_MTU_LIMIT:    cfg_mtu = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every word is in and every verdict out, then let the pipeline settle
   task automatic drain_block();
      while (wire_words.size() != 0 || expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase();
      int start;
      start = words_queued;
      config_phases++;
      while (words_queued - start < PHASE_WORDS) queue_random_header();
   endtask

   // Record each word transfer and advance the tracker
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         track_header_word(req_header_word, req_first_word);
         words_taken++;
         req_taken <= 1'b1;
      end else begin
         req_taken <= 1'b0;
      end
   end

   // Offer words in bursts with gaps; hold the payload while stalled
   always @(negedge clock) begin : drive_words
      logic offer;
      offer = req_valid && !req_taken;
      if (req_taken) wire_words.delete(0);
      if (!offer && wire_words.size() != 0) begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 5))
               0, 1: gap_left = 0;
               2: gap_left = $urandom_range(10, 40);
               default: gap_left = $urandom_range(1, 6);
            endcase
         end
         if (burst_left != 0) begin
            offer = 1'b1;
            burst_left--;
         end else begin
            gap_left--;
         end
      end
      req_valid <= offer;
      if (offer) begin
         req_header_word <= wire_words[0].word;
         req_first_word <= wire_words[0].first;
      end
   end

   // Stall verdicts on a changing pattern, with long hold-offs when asked
   always @(negedge clock) begin : drive_stall
      logic stall;
      if (hold_off_left > 0) begin
         stall = 1'b1;
         hold_off_left--;
      end else if (hold_offs_served != hold_offs_asked) begin
         hold_offs_served++;
         hold_off_left = HOLD_OFF_CYCLES - 1;
         stall = 1'b1;
      end else begin
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(24, 200);
         end
         mode_left--;
         case (rx_mode)
            RX_FREE:  stall = 1'b0;
            RX_LIGHT: stall = ($urandom_range(0, 3) == 0);
            RX_HEAVY: stall = ($urandom_range(0, 3) != 0);
            default:  stall = !rsp_stall;
         endcase
      end
      rsp_stall <= stall;
   end

   // Compare each verdict transfer with the oldest prediction
   always @(posedge clock) begin : check_verdicts
      header_result_type got;
      header_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{verdict: rsp_verdict, dispatch: rsp_dispatch, protocol: rsp_protocol_number,
                 payload: rsp_payload_length, header_bytes: rsp_header_bytes,
                 source: rsp_source_address, destination: rsp_destination_address};
         if (expected_verdicts.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("[%0t] verdict with none pending: %s", $realtime, describe(got));
         end else begin
            want = expected_verdicts.pop_front();
            headers_checked++;
            if (got !== want) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("[%0t] verdict mismatch", $realtime);
                  $display("   expected %s", describe(want));
                  $display("   actual   %s", describe(got));
               end
            end else begin
               verdict_seen[got.verdict]++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
                  expected_verdicts.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_header_word = '0;
      req_first_word = 1'b0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_HOST_ADDRESS;
      csr_data = '0;
      cfg_host = HOST_RESET;
      cfg_mtu = MTU_RESET;
      hdr_active = 1'b0;
      hdr_count = '0;
      hdr_expected = '0;
      hdr_sum = '0;
      hdr_checksum = '0;
      hdr_version = '0;
      hdr_length = '0;
      hdr_fragment = '0;
      hdr_protocol = '0;
      hdr_source = '0;
      hdr_destination = '0;
      rx_mode = RX_FREE;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed headers under the reset configuration
      config_phases = 1;
      queue_header(IP_VERSION, MIN_IHL, 16'd84, 16'h0000, PROTO_ICMP,
                   32'hC0A8_0001, 32'hC0A8_0002, 1'b1, 0);
      queue_header(IP_VERSION, MIN_IHL, 16'd28, DONT_FRAGMENT, PROTO_UDP,
                   32'h0A00_0001, 32'h0A00_0002, 1'b1, 0);
      queue_header(IP_VERSION, MIN_IHL, 16'd40, 16'h0000, PROTO_TCP,
                   32'h0102_0304, 32'h0506_0708, 1'b1, 0);
      queue_header(IP_VERSION, MIN_IHL, 16'd40, 16'h0000, PROTO_UDP,
                   32'h0102_0304, 32'h0506_0708, 1'b0, 0);
      queue_header(4'd6, MIN_IHL, 16'd40, 16'h0000, PROTO_UDP,
                   32'h0102_0304, 32'h0506_0708, 1'b1, 0);
      queue_header(IP_VERSION, MIN_IHL, MTU_RESET + 16'd1, 16'h0000, PROTO_UDP,
                   32'h0102_0304, 32'h0506_0708, 1'b1, 0);
      queue_header(IP_VERSION, MIN_IHL, MTU_RESET, 16'h0000, PROTO_ICMP,
                   32'h0102_0304, 32'h0506_0708, 1'b1, 0);
      queue_header(IP_VERSION, MIN_IHL, 16'd60, MF_BIT, PROTO_UDP,
                   32'h0102_0304, 32'h0506_0708, 1'b1, 0);
      queue_header(IP_VERSION, MIN_IHL, 16'd60, OFFSET_MASK, PROTO_UDP,
                   32'h0102_0304, 32'h0506_0708, 1'b1, 0);
      queue_header(IP_VERSION, 4'd0, 16'd0, 16'h0000, PROTO_UDP, '0, '0, 1'b1, 0);
      queue_header(IP_VERSION, 4'd4, 16'd0, 16'h0000, PROTO_UDP, '0, '0, 1'b1, 0);
      queue_stray_words(2);
      queue_header(IP_VERSION, 4'd15, 16'd60, 16'h0000, PROTO_ICMP,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
      queue_header(IP_VERSION, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
      queue_header(IP_VERSION, MIN_IHL, 16'd0, 16'h0000, PROTO_UDP, '0, '0, 1'b1, 0);
      // Restart part way through, then a word outside any header
      queue_header(IP_VERSION, MIN_IHL, 16'd40, 16'h0000, PROTO_UDP,
                   32'h1111_2222, 32'h3333_4444, 1'b1, 6);
      queue_header(IP_VERSION, MIN_IHL, 16'd40, 16'h0000, 8'd0, '0, '0, 1'b1, 0);
      queue_stray_words(1);
      drain_block();

      // Own address set, no length limit; receiver holds off for a long stretch
      write_register(CSR_HOST_ADDRESS, $urandom | 32'd1);
      write_register(CSR_MTU_LIMIT, 32'h0000_FFFF);
      queue_header(IP_VERSION, MIN_IHL, 16'd100, 16'h0000, PROTO_UDP,
                   32'h0102_0304, cfg_host, 1'b1, 0);
      queue_header(IP_VERSION, MIN_IHL, 16'd100, 16'h0000, PROTO_UDP,
                   32'h0102_0304, cfg_host ^ 32'd1, 1'b1, 0);
      run_random_phase();
      hold_offs_asked++;
      drain_block();

      // Broadcast-like address, smallest limit
      write_register(CSR_HOST_ADDRESS, 32'hFFFF_FFFF);
      write_register(CSR_MTU_LIMIT, 32'd20);
      run_random_phase();
      drain_block();

      // Any destination, random limit; an unmapped index must change nothing
      write_register(CSR_HOST_ADDRESS, 32'd0);
      write_register(CSR_MTU_LIMIT, $urandom_range(20, 65535));
      write_register(CSR_UNMAPPED, 32'hFFFF_FFFF);
      run_random_phase();
      hold_offs_asked++;
      drain_block();

      // Random address, default limit
      write_register(CSR_HOST_ADDRESS, $urandom);
      write_register(CSR_MTU_LIMIT, {16'd0, MTU_RESET});
      run_random_phase();
      drain_block();

      $display("Checked %0d headers from %0d word transfers across %0d configurations",
               headers_checked, words_taken, config_phases);
      $display("Verdicts: ok %0d, checksum %0d, version %0d, too long %0d, fragment %0d, %s",
               verdict_seen[VERDICT_OK], verdict_seen[VERDICT_CHECKSUM],
               verdict_seen[VERDICT_VERSION], verdict_seen[VERDICT_TOO_LONG],
               verdict_seen[VERDICT_FRAGMENT],
               $sformatf("not ours %0d, unsupported %0d, bad IHL %0d; %0d mismatches",
                         verdict_seen[VERDICT_NOT_OURS], verdict_seen[VERDICT_UNSUPPORTED],
                         verdict_seen[VERDICT_BAD_IHL], error_count));
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
